[rtl/core/aabbxf_pkg.sv]
// shared types and constants for the affine box transform
// no dependencies; used by every module of the block
`default_nettype none

package aabbxf_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int COEF_W    = 32;
  localparam int REG_W     = 64;
  localparam int NUM_REGS  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_ROWS  = 3;
  localparam int NUM_AXES  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;

  localparam logic [REG_W-1:0] RST_ROW0_C01 = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW0_C23 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_C01 = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_C23 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_C01 = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_C23 = 64'h0000_0000_0001_0000;

  localparam int NUM_STAGES = 6;

  typedef logic signed [COEF_W-1:0] coef_t;

  // one matrix row: three linear coefficients and the translation
  typedef struct packed {
    coef_t m0;
    coef_t m1;
    coef_t m2;
    coef_t t;
  } row_coef_t;

  // load enables, one per pipeline stage
  typedef struct packed {
    logic ld_in;
    logic mul;
    logic sel;
    logic add_a;
    logic add_b;
    logic fin;
  } pipe_en_t;

endpackage

`default_nettype wire

[rtl/core/aabbxf_cfg.sv]
// configuration register file for the affine box transform
// depends on aabbxf_pkg
`default_nettype none

module aabbxf_cfg (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aabbxf_pkg::REG_W-1:0]          cfg_data,
  output aabbxf_pkg::row_coef_t                 row_coef [aabbxf_pkg::NUM_ROWS]
);

  logic [aabbxf_pkg::REG_W-1:0] r0c01_r, r0c23_r, r1c01_r, r1c23_r, r2c01_r, r2c23_r;
  logic [aabbxf_pkg::REG_W-1:0] r0c01_nxt, r0c23_nxt, r1c01_nxt, r1c23_nxt;
  logic [aabbxf_pkg::REG_W-1:0] r2c01_nxt, r2c23_nxt;

  always_comb begin
    r0c01_nxt = r0c01_r;
    r0c23_nxt = r0c23_r;
    r1c01_nxt = r1c01_r;
    r1c23_nxt = r1c23_r;
    r2c01_nxt = r2c01_r;
    r2c23_nxt = r2c23_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        aabbxf_pkg::REG_ROW0_C01: r0c01_nxt = cfg_data;
        aabbxf_pkg::REG_ROW0_C23: r0c23_nxt = cfg_data;
        aabbxf_pkg::REG_ROW1_C01: r1c01_nxt = cfg_data;
        aabbxf_pkg::REG_ROW1_C23: r1c23_nxt = cfg_data;
        aabbxf_pkg::REG_ROW2_C01: r2c01_nxt = cfg_data;
        aabbxf_pkg::REG_ROW2_C23: r2c23_nxt = cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0c01_r <= aabbxf_pkg::RST_ROW0_C01;
      r0c23_r <= aabbxf_pkg::RST_ROW0_C23;
      r1c01_r <= aabbxf_pkg::RST_ROW1_C01;
      r1c23_r <= aabbxf_pkg::RST_ROW1_C23;
      r2c01_r <= aabbxf_pkg::RST_ROW2_C01;
      r2c23_r <= aabbxf_pkg::RST_ROW2_C23;
    end else begin
      r0c01_r <= r0c01_nxt;
      r0c23_r <= r0c23_nxt;
      r1c01_r <= r1c01_nxt;
      r1c23_r <= r1c23_nxt;
      r2c01_r <= r2c01_nxt;
      r2c23_r <= r2c23_nxt;
    end
  end

  // low half is the even column, high half the odd one (or translation)
  assign row_coef[0] = {r0c01_r[31:0], r0c01_r[63:32], r0c23_r[31:0], r0c23_r[63:32]};
  assign row_coef[1] = {r1c01_r[31:0], r1c01_r[63:32], r1c23_r[31:0], r1c23_r[63:32]};
  assign row_coef[2] = {r2c01_r[31:0], r2c01_r[63:32], r2c23_r[31:0], r2c23_r[63:32]};

endmodule

`default_nettype wire

[rtl/core/aabbxf_ctrl.sv]
// valid bits and stall control of the transform pipeline
// depends on aabbxf_pkg
`default_nettype none

module aabbxf_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output aabbxf_pkg::pipe_en_t  en
);

  localparam int NS = aabbxf_pkg::NUM_STAGES;

  logic [NS:1]   v_r, v_nxt;
  logic [NS+1:1] adv;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    adv[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[1]) begin
      v_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NS; k++) begin
      if (adv[k]) begin
        v_nxt[k] = v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = v_r[NS];

  assign en.ld_in = adv[1];
  assign en.mul   = adv[2];
  assign en.sel   = adv[3];
  assign en.add_a = adv[4];
  assign en.add_b = adv[5];
  assign en.fin   = adv[6];

endmodule

`default_nettype wire

[rtl/core/aabbxf_row.sv]
// datapath of one output axis: products, per-term min/max, sum, floor and saturate
// depends on aabbxf_pkg; stage loads come from aabbxf_ctrl
`default_nettype none

module aabbxf_row #(
  parameter int COORD_WIDTH = aabbxf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = aabbxf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  aabbxf_pkg::pipe_en_t           en,
  input  aabbxf_pkg::row_coef_t          coef,
  input  logic signed [COORD_WIDTH-1:0]  box_lo [aabbxf_pkg::NUM_AXES],
  input  logic signed [COORD_WIDTH-1:0]  box_hi [aabbxf_pkg::NUM_AXES],
  output logic signed [COORD_WIDTH-1:0]  res_min,
  output logic signed [COORD_WIDTH-1:0]  res_max
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int CFW = aabbxf_pkg::COEF_W;
  localparam int NA  = aabbxf_pkg::NUM_AXES;
  localparam int PW  = CFW + CW;
  localparam int TW  = CFW + FB;
  localparam int SW  = ((PW > TW) ? PW : TW) + 2;

  logic signed [CFW-1:0] m [NA];
  logic signed [CFW-1:0] tr;

  logic signed [PW-1:0] plo_r [NA], phi_r [NA];
  logic signed [PW-1:0] plo_nxt [NA], phi_nxt [NA];
  logic signed [PW-1:0] mn_r [NA], mx_r [NA];
  logic signed [PW-1:0] mn_nxt [NA], mx_nxt [NA];
  logic signed [SW-1:0] sa_min_r, sb_min_r, sa_max_r, sb_max_r;
  logic signed [SW-1:0] sa_min_nxt, sb_min_nxt, sa_max_nxt, sb_max_nxt;
  logic signed [SW-1:0] sum_min_r, sum_max_r;
  logic signed [CW-1:0] res_min_r, res_max_r;

  assign m[0] = $signed(coef.m0);
  assign m[1] = $signed(coef.m1);
  assign m[2] = $signed(coef.m2);
  assign tr   = $signed(coef.t);

  // floor shift, then clamp to the signed coordinate range
  function automatic logic signed [CW-1:0] fin_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] sh;
    logic [SW-CW:0]       upper;
    sh    = s >>> FB;
    upper = sh[SW-1:CW-1];
    if ((&upper) || !(|upper)) begin
      return sh[CW-1:0];
    end else if (sh[SW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  always_comb begin
    for (int c = 0; c < NA; c++) begin
      plo_nxt[c] = PW'(m[c]) * PW'(box_lo[c]);
      phi_nxt[c] = PW'(m[c]) * PW'(box_hi[c]);
    end
  end

  // each term is minimized or maximized on its own axis
  always_comb begin
    for (int c = 0; c < NA; c++) begin
      mn_nxt[c] = (plo_r[c] < phi_r[c]) ? plo_r[c] : phi_r[c];
      mx_nxt[c] = (plo_r[c] < phi_r[c]) ? phi_r[c] : plo_r[c];
    end
  end

  always_comb begin
    sa_min_nxt = (SW'(tr) <<< FB) + SW'(mn_r[0]);
    sb_min_nxt = SW'(mn_r[1]) + SW'(mn_r[2]);
    sa_max_nxt = (SW'(tr) <<< FB) + SW'(mx_r[0]);
    sb_max_nxt = SW'(mx_r[1]) + SW'(mx_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
    if (en.sel) begin
      mn_r <= mn_nxt;
      mx_r <= mx_nxt;
    end
    if (en.add_a) begin
      sa_min_r <= sa_min_nxt;
      sb_min_r <= sb_min_nxt;
      sa_max_r <= sa_max_nxt;
      sb_max_r <= sb_max_nxt;
    end
    if (en.add_b) begin
      sum_min_r <= sa_min_r + sb_min_r;
      sum_max_r <= sa_max_r + sb_max_r;
    end
    if (en.fin) begin
      res_min_r <= fin_sat(sum_min_r);
      res_max_r <= fin_sat(sum_max_r);
    end
  end

  assign res_min = res_min_r;
  assign res_max = res_max_r;

endmodule

`default_nettype wire

[rtl/core/aabb_affine_transform_top.sv]
// top level of the affine box transform: config registers, pipeline control, three axis datapaths
// depends on aabbxf_pkg, aabbxf_cfg, aabbxf_ctrl, aabbxf_row
`default_nettype none

// Takes an axis-aligned box (min and max corner, signed fixed point with FRAC_BITS
// fraction bits) and returns the axis-aligned box bounding its eight corners after
// the 3x4 affine map in the six 64-bit config registers (each holds two signed
// 32-bit coefficients, low half first). Sums are exact, floored by FRAC_BITS and
// saturated to COORD_WIDTH bits. One item is accepted per clock while no stall reaches
// the input; the stages from acceptance to out_valid are the input register, 32xCOORD_WIDTH
// multiply, per-term min/max, two adder stages, and the floor/saturate output register.
// Each stage holds on its own when full and blocked, so bubbles are squeezed out
// under output backpressure. Registers are to be written only while the pipeline
// is empty; writes to indexes 6 and 7 are ignored.
module aabb_affine_transform_top #(
  parameter int COORD_WIDTH = aabbxf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = aabbxf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [aabbxf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aabbxf_pkg::REG_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_min_z,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_x,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_y,
  input  logic signed [COORD_WIDTH-1:0]       in_box_max_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [COORD_WIDTH-1:0]       out_min_x,
  output logic signed [COORD_WIDTH-1:0]       out_min_y,
  output logic signed [COORD_WIDTH-1:0]       out_min_z,
  output logic signed [COORD_WIDTH-1:0]       out_max_x,
  output logic signed [COORD_WIDTH-1:0]       out_max_y,
  output logic signed [COORD_WIDTH-1:0]       out_max_z
);

  localparam int NA = aabbxf_pkg::NUM_AXES;
  localparam int NR = aabbxf_pkg::NUM_ROWS;

  aabbxf_pkg::row_coef_t row_coef [NR];
  aabbxf_pkg::pipe_en_t  en;

  logic signed [COORD_WIDTH-1:0] box_lo_r [NA], box_hi_r [NA];
  logic signed [COORD_WIDTH-1:0] res_min [NR], res_max [NR];

  aabbxf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_coef  (row_coef)
  );

  aabbxf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .en        (en)
  );

  always_ff @(posedge clk) begin
    if (en.ld_in) begin
      box_lo_r[0] <= in_box_min_x;
      box_lo_r[1] <= in_box_min_y;
      box_lo_r[2] <= in_box_min_z;
      box_hi_r[0] <= in_box_max_x;
      box_hi_r[1] <= in_box_max_y;
      box_hi_r[2] <= in_box_max_z;
    end
  end

  for (genvar r = 0; r < NR; r++) begin : g_row
    aabbxf_row #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_row (
      .clk     (clk),
      .en      (en),
      .coef    (row_coef[r]),
      .box_lo  (box_lo_r),
      .box_hi  (box_hi_r),
      .res_min (res_min[r]),
      .res_max (res_max[r])
    );
  end

  assign out_min_x = res_min[0];
  assign out_min_y = res_min[1];
  assign out_min_z = res_min[2];
  assign out_max_x = res_max[0];
  assign out_max_y = res_max[1];
  assign out_max_z = res_max[2];

endmodule

`default_nettype wire

[rtl/core/aabbxf_chk.sv]
// port-level checks for the affine box transform, bound to the top level
// depends on aabbxf_pkg and aabb_affine_transform_top
`default_nettype none

module aabbxf_chk #(
  parameter int COORD_WIDTH = aabbxf_pkg::COORD_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [COORD_WIDTH-1:0] out_min_x,
  input logic signed [COORD_WIDTH-1:0] out_min_y,
  input logic signed [COORD_WIDTH-1:0] out_min_z,
  input logic signed [COORD_WIDTH-1:0] out_max_x,
  input logic signed [COORD_WIDTH-1:0] out_max_y,
  input logic signed [COORD_WIDTH-1:0] out_max_z
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_min_x) && $stable(out_min_y)
      && $stable(out_min_z) && $stable(out_max_x) && $stable(out_max_y)
      && $stable(out_max_z))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an output side that drains never blocks the input
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with free output");

  // the bounding box is always ordered
  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
      && (out_min_z <= out_max_z))
    else $error("result box inverted");

endmodule

bind aabb_affine_transform_top aabbxf_chk #(.COORD_WIDTH(COORD_WIDTH)) u_aabbxf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_min_x (out_min_x),
  .out_min_y (out_min_y),
  .out_min_z (out_min_z),
  .out_max_x (out_max_x),
  .out_max_y (out_max_y),
  .out_max_z (out_max_z)
);

`default_nettype wire

[sim/tb_aabb_affine_transform_top.sv]
// testbench for aabb_affine_transform_top: directed table, then randomized config phases
// depends on aabbxf_pkg and the rtl of the block; items checked against an in-bench predictor

module tb_aabb_affine_transform_top;

  localparam int CW             = aabbxf_pkg::COORD_WIDTH_DEF;
  localparam int FRAC           = aabbxf_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES  = 2 * aabbxf_pkg::NUM_STAGES + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 220;
  localparam int MAX_REPORTS    = 100;

  // indexes that hold no register; writes there must be dropped
  localparam logic [aabbxf_pkg::CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [aabbxf_pkg::CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  localparam logic [31:0] C_MIN  = 32'h8000_0000;
  localparam logic [31:0] C_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;

  // coordinate slots: 0..2 lower x,y,z then 3..5 upper x,y,z
  typedef logic [5:0][CW-1:0] box_t;
  typedef logic signed [79:0] wide_t;

  typedef enum logic { ST_BOX, ST_CFG } step_kind_t;
  typedef enum int { CK_IDENTITY, CK_SMALL, CK_FULL, CK_EXTREME } coef_kind_t;

  typedef struct {
    step_kind_t                       kind;
    logic [aabbxf_pkg::CFG_IDX_W-1:0] idx;
    logic [aabbxf_pkg::REG_W-1:0]     data;
    box_t                             box;
    bit                               typed;
    box_t                             want;
  } plan_row_t;

  localparam wide_t SAT_HI = (wide_t'(1) <<< (CW - 1)) - 1;
  localparam wide_t SAT_LO = -(wide_t'(1) <<< (CW - 1));

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [aabbxf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [aabbxf_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  box_t in_box = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_min_x, out_min_y, out_min_z;
  logic signed [CW-1:0] out_max_x, out_max_y, out_max_z;

  logic [aabbxf_pkg::REG_W-1:0] coef_regs [aabbxf_pkg::NUM_REGS];
  box_t expected_boxes [$];
  plan_row_t plan [$];
  string field_name [6] = '{"out_min_x", "out_min_y", "out_min_z",
                            "out_max_x", "out_max_y", "out_max_z"};

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int boxes_checked  = 0;
  int quiet_cycles   = 0;

  aabb_affine_transform_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_box_min_x (in_box[0]),
    .in_box_min_y (in_box[1]),
    .in_box_min_z (in_box[2]),
    .in_box_max_x (in_box[3]),
    .in_box_max_y (in_box[4]),
    .in_box_max_z (in_box[5]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_min_x    (out_min_x),
    .out_min_y    (out_min_y),
    .out_min_z    (out_min_z),
    .out_max_x    (out_max_x),
    .out_max_y    (out_max_y),
    .out_max_z    (out_max_z)
  );

  always #5 clk = ~clk;

  function automatic box_t mk_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                                  logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz);
    box_t b;
    b[0] = lx; b[1] = ly; b[2] = lz;
    b[3] = hx; b[4] = hy; b[5] = hz;
    return b;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(wide_t v);
    if (v > SAT_HI) return C_MAX;
    if (v < SAT_LO) return C_MIN;
    return v[CW-1:0];
  endfunction

  // per term the smaller and larger product go to the lower and upper sums
  function automatic box_t bound_transformed(box_t b);
    box_t r;
    logic [aabbxf_pkg::REG_W-1:0] c01, c23;
    logic signed [31:0] m [3];
    logic signed [31:0] t;
    logic signed [63:0] p_lo, p_hi;
    wide_t acc_min, acc_max;
    for (int row = 0; row < aabbxf_pkg::NUM_ROWS; row++) begin
      c01 = coef_regs[2*row];
      c23 = coef_regs[2*row+1];
      m[0] = c01[31:0];
      m[1] = c01[63:32];
      m[2] = c23[31:0];
      t    = c23[63:32];
      acc_min = wide_t'(t) <<< FRAC;
      acc_max = acc_min;
      for (int ax = 0; ax < aabbxf_pkg::NUM_AXES; ax++) begin
        p_lo = m[ax] * $signed(b[ax]);
        p_hi = m[ax] * $signed(b[ax+3]);
        if (p_lo < p_hi) begin
          acc_min += wide_t'(p_lo);
          acc_max += wide_t'(p_hi);
        end else begin
          acc_min += wide_t'(p_hi);
          acc_max += wide_t'(p_lo);
        end
      end
      r[row]   = clamp_coord(acc_min >>> FRAC);
      r[row+3] = clamp_coord(acc_max >>> FRAC);
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      2: return 32'($urandom_range(0, 2)) - 32'd1;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
    endcase
  endfunction

  function automatic logic [31:0] rand_coef(coef_kind_t kind);
    case (kind)
      CK_SMALL: return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
      CK_FULL:  return $urandom;
      default: begin
        case ($urandom_range(0, 5))
          0: return C_MIN;
          1: return C_MAX;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          4: return Q_ONE;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  function automatic void add_box(box_t b, bit typed, box_t want);
    plan_row_t p;
    p.kind = ST_BOX; p.idx = '0; p.data = '0;
    p.box = b; p.typed = typed; p.want = want;
    plan.push_back(p);
  endfunction

  function automatic void add_cfg(logic [aabbxf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [aabbxf_pkg::REG_W-1:0] data);
    plan_row_t p;
    p.kind = ST_CFG; p.idx = idx; p.data = data;
    p.box = '0; p.typed = 1'b0; p.want = '0;
    plan.push_back(p);
  endfunction

  task automatic cfg_write(logic [aabbxf_pkg::CFG_IDX_W-1:0] idx,
                           logic [aabbxf_pkg::REG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < aabbxf_pkg::NUM_REGS) coef_regs[idx] = data;
  endtask

  // valid stays up across back-to-back items; it only drops in a gap
  task automatic send_box(box_t b, bit typed, box_t want);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_box   <= b;
    do @(posedge clk); while (!in_ready);
    expected_boxes.push_back(typed ? want : bound_transformed(b));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (recv_stall_pct > 0) out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin : check_results
    box_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = mk_box(out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z);
      boxes_checked++;
      if (expected_boxes.size() == 0) begin
        if (mismatches < MAX_REPORTS) $error("result item with nothing expected: %h", got);
        mismatches++;
      end else begin
        want = expected_boxes.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            if (mismatches < MAX_REPORTS)
              $error("%s expected %h got %h", field_name[i], want[i], got[i]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    box_t unit_box, all_min, all_max, span, trans;
    bit prev_cfg;
    coef_kind_t kind;

    coef_regs[0] = aabbxf_pkg::RST_ROW0_C01;
    coef_regs[1] = aabbxf_pkg::RST_ROW0_C23;
    coef_regs[2] = aabbxf_pkg::RST_ROW1_C01;
    coef_regs[3] = aabbxf_pkg::RST_ROW1_C23;
    coef_regs[4] = aabbxf_pkg::RST_ROW2_C01;
    coef_regs[5] = aabbxf_pkg::RST_ROW2_C23;

    unit_box = mk_box(32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000, 32'h6_0000);
    all_min  = mk_box(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
    all_max  = mk_box(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
    span     = mk_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
    trans    = mk_box(32'h1234_5678, 32'hfedc_ba98, C_MIN, 32'h1234_5678, 32'hfedc_ba98, C_MIN);

    // identity after reset
    add_box(unit_box, 1, unit_box);
    add_box(mk_box(32'h4_0000, 32'h5_0000, 32'h6_0000, 32'h1_0000, 32'h2_0000, 32'h3_0000),
            1, unit_box);
    add_box(span, 1, span);
    add_box('0, 1, '0);
    add_box(mk_box(32'hffff_7fff, 32'hffff_ffff, 32'h0000_8001,
                   32'h0000_0001, 32'hffff_0000, 32'hffff_8000), 0, '0);
    // halves and negative halves, so the floor shift sees odd negative sums
    add_cfg(aabbxf_pkg::REG_ROW0_C01, {32'h0000_8000, 32'hffff_8000});
    add_cfg(aabbxf_pkg::REG_ROW1_C23, {32'hffff_ffff, 32'h0001_8000});
    add_box(mk_box(32'hffff_ffff, 32'h0000_0001, 32'h0000_0003,
                   32'h0000_0003, 32'hffff_fffd, 32'hffff_ffff), 0, '0);
    add_box(mk_box(32'h0000_0001, 32'hffff_ffff, 32'hffff_8001,
                   32'hffff_ffff, 32'h0000_0001, 32'h0000_7fff), 0, '0);
    // every coefficient at the top: both bounds clip high for the all-max box
    for (int i = 0; i < aabbxf_pkg::NUM_REGS; i++)
      add_cfg(aabbxf_pkg::CFG_IDX_W'(i), {C_MAX, C_MAX});
    add_box(all_max, 1, all_max);
    add_box(span, 1, span);
    // every coefficient at the bottom: three products overflow 64 bits together
    for (int i = 0; i < aabbxf_pkg::NUM_REGS; i++)
      add_cfg(aabbxf_pkg::CFG_IDX_W'(i), {C_MIN, C_MIN});
    add_box(all_min, 1, all_max);
    add_box(all_max, 1, all_min);
    // pure translation; writes to the spare indexes must change nothing
    add_cfg(aabbxf_pkg::REG_ROW0_C01, '0);
    add_cfg(aabbxf_pkg::REG_ROW0_C23, {32'h1234_5678, 32'h0});
    add_cfg(aabbxf_pkg::REG_ROW1_C01, '0);
    add_cfg(aabbxf_pkg::REG_ROW1_C23, {32'hfedc_ba98, 32'h0});
    add_cfg(aabbxf_pkg::REG_ROW2_C01, '0);
    add_cfg(aabbxf_pkg::REG_ROW2_C23, {C_MIN, 32'h0});
    add_cfg(REG_SPARE6, '1);
    add_cfg(REG_SPARE7, 64'h5a5a_5a5a_a5a5_a5a5);
    add_box(span, 1, trans);
    add_box(unit_box, 1, trans);
    // a general map with mixed signs
    add_cfg(aabbxf_pkg::REG_ROW0_C01, {32'hfffe_8000, 32'h0002_0000});
    add_cfg(aabbxf_pkg::REG_ROW0_C23, {32'hfffd_0000, 32'h0000_4000});
    add_cfg(aabbxf_pkg::REG_ROW1_C01, {32'h0000_b505, 32'hffff_4afb});
    add_cfg(aabbxf_pkg::REG_ROW1_C23, {32'h0010_0000, 32'h0000_0001});
    add_cfg(aabbxf_pkg::REG_ROW2_C01, {32'h0000_0003, 32'h8000_0001});
    add_cfg(aabbxf_pkg::REG_ROW2_C23, {32'hffff_ffff, 32'h0003_0000});
    add_box(unit_box, 0, '0);
    add_box(span, 0, '0);
    add_box(mk_box(32'h7fff_0000, 32'h8000_ffff, 32'h0, 32'h8000_0001, 32'h7fff_ffff, 32'h1),
            0, '0);
    // back to the reset values
    add_cfg(aabbxf_pkg::REG_ROW0_C01, aabbxf_pkg::RST_ROW0_C01);
    add_cfg(aabbxf_pkg::REG_ROW0_C23, aabbxf_pkg::RST_ROW0_C23);
    add_cfg(aabbxf_pkg::REG_ROW1_C01, aabbxf_pkg::RST_ROW1_C01);
    add_cfg(aabbxf_pkg::REG_ROW1_C23, aabbxf_pkg::RST_ROW1_C23);
    add_cfg(aabbxf_pkg::REG_ROW2_C01, aabbxf_pkg::RST_ROW2_C01);
    add_cfg(aabbxf_pkg::REG_ROW2_C23, aabbxf_pkg::RST_ROW2_C23);
    add_box(unit_box, 1, unit_box);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ST_CFG) begin
        if (!prev_cfg) settle();
        cfg_write(plan[i].idx, plan[i].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_wr_en <= 1'b0;
        send_box(plan[i].box, plan[i].typed, plan[i].want);
        prev_cfg = 1'b0;
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      kind = coef_kind_t'((ph + ph / 4) % 4);
      for (int i = 0; i < aabbxf_pkg::NUM_REGS; i++) begin
        if (kind == CK_IDENTITY) begin
          case (i)
            0: cfg_write(aabbxf_pkg::REG_ROW0_C01, aabbxf_pkg::RST_ROW0_C01);
            1: cfg_write(aabbxf_pkg::REG_ROW0_C23, aabbxf_pkg::RST_ROW0_C23);
            2: cfg_write(aabbxf_pkg::REG_ROW1_C01, aabbxf_pkg::RST_ROW1_C01);
            3: cfg_write(aabbxf_pkg::REG_ROW1_C23, aabbxf_pkg::RST_ROW1_C23);
            4: cfg_write(aabbxf_pkg::REG_ROW2_C01, aabbxf_pkg::RST_ROW2_C01);
            default: cfg_write(aabbxf_pkg::REG_ROW2_C23, aabbxf_pkg::RST_ROW2_C23);
          endcase
        end else begin
          cfg_write(aabbxf_pkg::CFG_IDX_W'(i), {rand_coef(kind), rand_coef(kind)});
        end
      end
      if ($urandom_range(0, 1) == 1) cfg_write(REG_SPARE6, {$urandom, $urandom});
      if ($urandom_range(0, 1) == 1) cfg_write(REG_SPARE7, {$urandom, $urandom});
      cfg_wr_en <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_box(mk_box(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord()), 0, '0);
    end

    settle();
    $display("summary: %0d result items checked across %0d directed rows and %0d config phases",
             boxes_checked, plan.size(), NUM_PHASES);
    $display("summary: identity, translation, extreme and random coefficients; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_boxes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
